// ===== rtl/core/psma_pkg.sv =====
// ----------------------------------------------------------------------------
// psma_pkg: shared types and constants for the pose slew limiter / averager
// Holds field widths, register codes, the pose struct and the table of
// reciprocals that the mean unit uses to divide by the history length.
// ----------------------------------------------------------------------------
package psma_pkg;

    localparam int DATA_W     = 32;   // position fields, Q16.16
    localparam int QUAT_W     = 16;   // quaternion fields, Q1.14
    localparam int STEP_W     = 31;   // step limit registers
    localparam int TDATA_W    = 160;  // 3 x 32 + 4 x 16
    localparam int QUATS_W    = 4 * QUAT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Divider: magnitude width, reciprocal width and operand split
    localparam int ABS_W      = 36;   // |sum| of up to 16 entries
    localparam int RECIP_W    = 40;
    localparam int RECIP_SH   = 40;   // reciprocal scale 2^40
    localparam int SPLIT_A    = 18;   // low half of the magnitude
    localparam int SPLIT_M    = 20;   // low half of the reciprocal
    localparam int PP_W       = (ABS_W - SPLIT_A) + (RECIP_W - SPLIT_M);
    localparam int PROD_W     = ABS_W + RECIP_W;
    localparam int NIDX_W     = 5;    // count index into the reciprocal table

    // Output queue
    localparam int FIFO_DEPTH = 8;

    // Register reset values
    localparam logic [STEP_W-1:0]        STEP_XY_RST = 31'd65536;
    localparam logic [STEP_W-1:0]        STEP_Z_RST  = 31'd16384;
    localparam logic signed [DATA_W-1:0] GATE_RST    = 32'sd262144;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_XY = 2'd0,
        CFG_STEP_Z  = 2'd1,
        CFG_GATE    = 2'd2
    } t_cfg_idx;

    // One stored pose
    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } t_pos;

    // ceil(2^40 / n); a count below two never reaches the divider
    function automatic logic [RECIP_W-1:0] psma_recip(input logic [NIDX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                5'd2:    r = 40'd549755813888;
                5'd3:    r = 40'd366503875926;
                5'd4:    r = 40'd274877906944;
                5'd5:    r = 40'd219902325556;
                5'd6:    r = 40'd183251937963;
                5'd7:    r = 40'd157073089683;
                5'd8:    r = 40'd137438953472;
                5'd9:    r = 40'd122167958642;
                5'd10:   r = 40'd109951162778;
                5'd11:   r = 40'd99955602526;
                5'd12:   r = 40'd91625968982;
                5'd13:   r = 40'd84577817522;
                5'd14:   r = 40'd78536544842;
                5'd15:   r = 40'd73300775186;
                5'd16:   r = 40'd68719476736;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/psma_cell.sv =====
// ----------------------------------------------------------------------------
// psma_cell: one entry of the pose history
// Holds one stored pose and passes it to the next cell on every push, so a
// row of cells forms the newest-first history.
// ----------------------------------------------------------------------------
module psma_cell
    import psma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  t_pos i_pos,
    output t_pos o_pos
);

    t_pos r_pos;

    // Take the neighbor's pose on a push; history starts all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_shift) begin
            r_pos <= i_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

// ===== rtl/core/psma_clamp.sv =====
// ----------------------------------------------------------------------------
// psma_clamp: step limiter for one axis
// Bounds a measurement to newest +/- step, with both bounds saturated at the
// signed 32-bit range.
// ----------------------------------------------------------------------------
module psma_clamp
    import psma_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_meas,
    input  logic signed [DATA_W-1:0] i_last,
    input  logic        [STEP_W-1:0] i_step,
    output logic signed [DATA_W-1:0] o_clamped
);

    localparam int EXT_W = DATA_W + 2;
    localparam logic signed [EXT_W-1:0] LIM_MIN = -(EXT_W'(64'sd2147483648));
    localparam logic signed [EXT_W-1:0] LIM_MAX = EXT_W'(64'sd2147483647);

    logic signed [EXT_W-1:0] w_last;
    logic signed [EXT_W-1:0] w_step;
    logic signed [EXT_W-1:0] w_meas;
    logic signed [EXT_W-1:0] w_lo;
    logic signed [EXT_W-1:0] w_hi;
    logic signed [EXT_W-1:0] w_lo_sat;
    logic signed [EXT_W-1:0] w_hi_sat;
    logic signed [EXT_W-1:0] w_val;

    // Form saturated bounds, then clamp from above and below
    always_comb begin
        w_last   = EXT_W'(i_last);
        w_meas   = EXT_W'(i_meas);
        w_step   = signed'({{(EXT_W-STEP_W){1'b0}}, i_step});
        w_lo     = w_last - w_step;
        w_hi     = w_last + w_step;
        w_lo_sat = (w_lo < LIM_MIN) ? LIM_MIN : w_lo;
        w_hi_sat = (w_hi > LIM_MAX) ? LIM_MAX : w_hi;
        w_val    = (w_meas > w_hi_sat) ? w_hi_sat : w_meas;
        if (w_val < w_lo_sat) begin
            w_val = w_lo_sat;
        end
    end

    assign o_clamped = w_val[DATA_W-1:0];

endmodule

// ===== rtl/core/psma_mean.sv =====
// ----------------------------------------------------------------------------
// psma_mean: running window sum and mean for one axis
// Keeps the sum of all history cells, then divides it by the entry count
// through a reciprocal multiply split into four partial products.
// Registered in turn: sum, magnitude, partial products, quotient, result.
// ----------------------------------------------------------------------------
module psma_mean
    import psma_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_upd,
    input  logic signed [DATA_W-1:0]         i_new,
    input  logic signed [DATA_W-1:0]         i_old,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0] i_cnt,
    output logic signed [DATA_W-1:0]         o_avg
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH);

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        r_cnt;

    logic [ABS_W:0]          w_ext;
    logic [ABS_W:0]          w_neg;
    logic [ABS_W-1:0]        r_mag;
    logic [RECIP_W-1:0]      r_recip;
    logic                    r_sgn_a;

    logic [PP_W-1:0]         r_pp11;
    logic [PP_W-1:0]         r_pp10;
    logic [PP_W-1:0]         r_pp01;
    logic [PP_W-1:0]         r_pp00;
    logic                    r_sgn_b;

    logic [PROD_W-1:0]       w_prod;
    logic [DATA_W-1:0]       r_quo;
    logic                    r_sgn_c;

    logic signed [DATA_W-1:0] r_avg;

    // Add the newest entry and drop the one that leaves the last cell
    assign n_sum = r_sum + SUM_W'(i_new) - SUM_W'(i_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_upd) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_cnt <= i_cnt;
        end
    end

    // Split into sign and magnitude, look up the reciprocal
    assign w_ext = (ABS_W+1)'(r_sum);
    assign w_neg = -w_ext;

    always_ff @(posedge i_clk) begin
        r_sgn_a <= r_sum[SUM_W-1];
        r_mag   <= r_sum[SUM_W-1] ? w_neg[ABS_W-1:0] : w_ext[ABS_W-1:0];
        r_recip <= psma_recip(NIDX_W'(r_cnt));
    end

    // Four partial products of the reciprocal multiply
    always_ff @(posedge i_clk) begin
        r_pp11  <= PP_W'(r_mag[ABS_W-1:SPLIT_A]) * PP_W'(r_recip[RECIP_W-1:SPLIT_M]);
        r_pp10  <= PP_W'(r_mag[ABS_W-1:SPLIT_A]) * PP_W'(r_recip[SPLIT_M-1:0]);
        r_pp01  <= PP_W'(r_mag[SPLIT_A-1:0]) * PP_W'(r_recip[RECIP_W-1:SPLIT_M]);
        r_pp00  <= PP_W'(r_mag[SPLIT_A-1:0]) * PP_W'(r_recip[SPLIT_M-1:0]);
        r_sgn_b <= r_sgn_a;
    end

    // Sum the partial products and keep the integer quotient
    assign w_prod = (PROD_W'(r_pp11) << (SPLIT_A + SPLIT_M))
                  + (PROD_W'(r_pp10) << SPLIT_A)
                  + (PROD_W'(r_pp01) << SPLIT_M)
                  + PROD_W'(r_pp00);

    always_ff @(posedge i_clk) begin
        r_quo   <= w_prod[RECIP_SH +: DATA_W];
        r_sgn_c <= r_sgn_b;
    end

    // Restore the sign: truncation toward zero
    always_ff @(posedge i_clk) begin
        r_avg <= r_sgn_c ? signed'(-r_quo) : signed'(r_quo);
    end

    assign o_avg = r_avg;

endmodule

// ===== rtl/core/pose_slew_limit_moving_average.sv =====
// ----------------------------------------------------------------------------
// pose_slew_limit_moving_average: gated, step-limited pose moving average
// Drops poses whose x or y lies above the gate, clamps each axis to a step
// around the newest stored pose, shifts the pose into a row of history cells
// and returns the per-axis mean of the history with the quaternion attached.
//
//   Channel    | Dir | Handshake           | Payload
//   s_axis     | in  | tvalid / tready     | pos x,y,z, quat w,x,y,z
//   m_axis     | out | tvalid / tready     | avg x,y,z, quat w,x,y,z
//   cfg        | in  | wr_en (no wait)     | index, data
//
// One item per cycle is accepted while input ready is high; a result passes
// through clamp and push, window sum, four divider stages and output queue.
// The step clamp reads the first history cell, which is written in the same
// cycle, so consecutive items chain through that cell with no bubble.
// Reset is synchronous and returns the history to a single zero pose.
// An eight-entry output queue absorbs stalls; input ready drops only when
// every queue slot is reserved by an item in flight or waiting.
// ----------------------------------------------------------------------------
module pose_slew_limit_moving_average
    import psma_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // s_axis
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [111:96] quat_w,
    // [127:112] quat_x, [143:128] quat_y, [159:144] quat_z
    input  logic [TDATA_W-1:0]    i_s_axis_tdata,
    // m_axis
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [31:0] avg_x, [63:32] avg_y, [95:64] avg_z, [111:96] out_quat_w,
    // [127:112] out_quat_x, [143:128] out_quat_y, [159:144] out_quat_z
    output logic [TDATA_W-1:0]    o_m_axis_tdata,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int LAT     = 6;                     // push to mean result
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CRED_W  = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic [STEP_W-1:0]        r_step_xy;
    logic [STEP_W-1:0]        r_step_z;
    logic signed [DATA_W-1:0] r_gate;

    // Input side
    t_pos                     w_in;
    t_pos                     w_clamp;
    logic                     w_acc;
    logic                     w_gated;
    logic                     w_push;

    // History chain and count
    t_pos                     w_cell [WINDOW_DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    // Pipeline toward the mean units
    t_pos                     r_s0_new;
    t_pos                     r_s0_old;
    logic [CNT_W-1:0]         r_s0_cnt;
    logic [LAT-1:0]           r_vld;
    logic [QUATS_W-1:0]       r_quat [LAT];
    t_pos                     w_avg;

    // Output queue
    logic [TDATA_W-1:0]       r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [CRED_W-1:0]        r_fill;
    logic [CRED_W-1:0]        r_credit;
    logic                     w_pop;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_xy <= STEP_XY_RST;
            r_step_z  <= STEP_Z_RST;
            r_gate    <= GATE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_XY: r_step_xy <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Z:  r_step_z  <= i_cfg_data[STEP_W-1:0];
                CFG_GATE:    r_gate    <= signed'(i_cfg_data);
                default:     ;
            endcase
        end
    end

    // Unpack the transaction and apply the gate
    assign w_in.x  = signed'(i_s_axis_tdata[31:0]);
    assign w_in.y  = signed'(i_s_axis_tdata[63:32]);
    assign w_in.z  = signed'(i_s_axis_tdata[95:64]);
    assign w_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_gated = (w_in.x > r_gate) || (w_in.y > r_gate);
    assign w_push  = w_acc & ~w_gated;

    // Clamp each axis around the newest stored pose
    psma_clamp u_clamp_x (
        .i_meas    (w_in.x),
        .i_last    (w_cell[0].x),
        .i_step    (r_step_xy),
        .o_clamped (w_clamp.x)
    );

    psma_clamp u_clamp_y (
        .i_meas    (w_in.y),
        .i_last    (w_cell[0].y),
        .i_step    (r_step_xy),
        .o_clamped (w_clamp.y)
    );

    psma_clamp u_clamp_z (
        .i_meas    (w_in.z),
        .i_last    (w_cell[0].z),
        .i_step    (r_step_z),
        .o_clamped (w_clamp.z)
    );

    // History row: newest in the first cell, oldest in the last
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            psma_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_push),
                .i_pos   (w_clamp),
                .o_pos   (w_cell[g])
            );
        end else begin : g_body
            psma_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_push),
                .i_pos   (w_cell[g-1]),
                .o_pos   (w_cell[g])
            );
        end
    end

    // Grow the entry count until the window is full
    assign n_count = (r_count < CNT_W'(WINDOW_DEPTH)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
        end else if (w_push) begin
            r_count <= n_count;
        end
    end

    // Hand the pushed pose and the evicted pose to the mean units
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_s0_new <= w_clamp;
            r_s0_old <= w_cell[WINDOW_DEPTH-1];
            r_s0_cnt <= n_count;
        end
    end

    // Track valid items and their quaternions alongside the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_push};
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat[0] <= i_s_axis_tdata[TDATA_W-1:3*DATA_W];
        for (int i = 1; i < LAT; i++) begin
            r_quat[i] <= r_quat[i-1];
        end
    end

    psma_mean #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_mean_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (r_vld[0]),
        .i_new   (r_s0_new.x),
        .i_old   (r_s0_old.x),
        .i_cnt   (r_s0_cnt),
        .o_avg   (w_avg.x)
    );

    psma_mean #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_mean_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (r_vld[0]),
        .i_new   (r_s0_new.y),
        .i_old   (r_s0_old.y),
        .i_cnt   (r_s0_cnt),
        .o_avg   (w_avg.y)
    );

    psma_mean #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_mean_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (r_vld[0]),
        .i_new   (r_s0_new.z),
        .i_old   (r_s0_old.z),
        .i_cnt   (r_s0_cnt),
        .o_avg   (w_avg.z)
    );

    // Queue finished results
    assign w_pop = o_m_axis_tvalid & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_vld[LAT-1]) begin
            r_fifo[r_wr_ptr] <= {r_quat[LAT-1], w_avg.z, w_avg.y, w_avg.x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (r_vld[LAT-1]) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill   <= r_fill + CRED_W'(r_vld[LAT-1]) - CRED_W'(w_pop);
            r_credit <= r_credit + CRED_W'(w_push) - CRED_W'(w_pop);
        end
    end

    // Reserve a queue slot for every pushed pose
    assign o_s_axis_tready = (r_credit < CRED_W'(FIFO_DEPTH));
    assign o_m_axis_tvalid = (r_fill != '0);
    assign o_m_axis_tdata  = r_fifo[r_rd_ptr];

endmodule

// ===== rtl/core/psma_checker.sv =====
// ----------------------------------------------------------------------------
// psma_checker: port-level checks for the pose slew limiter / averager
// Watches the top level's ports for reset behavior, output stalls and the
// relation between input backpressure and waiting results.
// ----------------------------------------------------------------------------
module psma_checker
    import psma_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [TDATA_W-1:0]    o_m_axis_tdata
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Backpressure only while results are waiting
    a_ready_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result waiting");

    // Ready drops only right after a waiting result was not taken
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready dropped while output drained");

endmodule

bind pose_slew_limit_moving_average psma_checker u_psma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/sv/pose_mean_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_mean_monitor: prediction and scoreboard for the pose slew limiter
// Watches the register write port, the input stream and the output stream.
// Each accepted input pose is run through a local copy of the gate, the step
// clamp and the history window; every pose that passes the gate queues one
// expected mean. Each accepted output is checked field by field against the
// oldest queued mean. Counts go back to the top level for the verdict.
// ----------------------------------------------------------------------------
module pose_mean_monitor
    import psma_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [TDATA_W-1:0]    i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [TDATA_W-1:0]    i_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_poses_in,
    output int                    o_means_out,
    output int                    o_gated
);

    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    // One stream word; the first field sits in the lowest bits
    typedef struct packed {
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qw;
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } t_pose_word;

    // Local copy of the registers and the history window
    logic [STEP_W-1:0]        step_xy;
    logic [STEP_W-1:0]        step_z;
    logic signed [DATA_W-1:0] gate_level;
    logic signed [DATA_W-1:0] hist_x [WINDOW_DEPTH];
    logic signed [DATA_W-1:0] hist_y [WINDOW_DEPTH];
    logic signed [DATA_W-1:0] hist_z [WINDOW_DEPTH];
    int                       hist_len;

    t_pose_word expected_means[$];
    t_pose_word want;
    t_pose_word got;
    int         fails;
    int         poses_in;
    int         means_out;
    int         gated;

    // Clamp one axis to within step of the newest stored value
    function automatic logic signed [DATA_W-1:0] clamp_axis(
        input logic signed [DATA_W-1:0] meas,
        input logic signed [DATA_W-1:0] newest,
        input logic [STEP_W-1:0]        step
    );
        longint lo;
        longint hi;
        longint v;
        lo = longint'(newest) - longint'({1'b0, step});
        hi = longint'(newest) + longint'({1'b0, step});
        v  = longint'(meas);
        if (lo < S32_MIN) lo = S32_MIN;
        if (hi > S32_MAX) hi = S32_MAX;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return 32'(v);
    endfunction

    // Gate, clamp, push into the window and average; returns 0 when gated
    function automatic bit filter_pose(input t_pose_word item, output t_pose_word mean);
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [DATA_W-1:0] cz;
        longint sx;
        longint sy;
        longint sz;
        mean = item;
        if (item.x > gate_level || item.y > gate_level) return 1'b0;
        cx = clamp_axis(item.x, hist_x[0], step_xy);
        cy = clamp_axis(item.y, hist_y[0], step_xy);
        cz = clamp_axis(item.z, hist_z[0], step_z);
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
            hist_x[i] = hist_x[i-1];
            hist_y[i] = hist_y[i-1];
            hist_z[i] = hist_z[i-1];
        end
        hist_x[0] = cx;
        hist_y[0] = cy;
        hist_z[0] = cz;
        if (hist_len < WINDOW_DEPTH) hist_len++;
        sx = 0;
        sy = 0;
        sz = 0;
        for (int i = 0; i < hist_len; i++) begin
            sx += longint'(hist_x[i]);
            sy += longint'(hist_y[i]);
            sz += longint'(hist_z[i]);
        end
        // Signed division truncates toward zero
        mean.x = 32'(sx / longint'(hist_len));
        mean.y = 32'(sy / longint'(hist_len));
        mean.z = 32'(sz / longint'(hist_len));
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // Track registers, predict each input transaction, score each output transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_xy    = STEP_XY_RST;
            step_z     = STEP_Z_RST;
            gate_level = GATE_RST;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
                hist_z[i] = '0;
            end
            hist_len = 1;
            expected_means.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_STEP_XY: step_xy = i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Z:  step_z = i_cfg_data[STEP_W-1:0];
                    CFG_GATE:    gate_level = i_cfg_data;
                    default: ;
                endcase
            end
            // Score the output before queueing a new prediction
            if (i_out_valid && i_out_ready) begin
                means_out++;
                got = i_out_data;
                if (expected_means.size() == 0) begin
                    $display("%0t ns: output transaction with no mean expected, actual %h",
                             $time, got);
                    fails++;
                end else begin
                    want = expected_means.pop_front();
                    check_field("avg_x", want.x, got.x);
                    check_field("avg_y", want.y, got.y);
                    check_field("avg_z", want.z, got.z);
                    check_field("quat_w", want.qw, got.qw);
                    check_field("quat_x", want.qx, got.qx);
                    check_field("quat_y", want.qy, got.qy);
                    check_field("quat_z", want.qz, got.qz);
                end
            end
            if (i_in_valid && i_in_ready) begin
                poses_in++;
                if (filter_pose(t_pose_word'(i_in_data), want))
                    expected_means.push_back(want);
                else
                    gated++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_means.size();
        o_poses_in   <= poses_in;
        o_means_out  <= means_out;
        o_gated      <= gated;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pose slew limiter / moving average
// Drives directed poses (gate edge, range extremes, window fill) and then
// random poses under several register settings, with random gaps on both
// streams, one long output hold-off and one stretch without gaps. Checking
// is done by pose_mean_monitor; this module only gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import psma_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RST_CYCLES     = 7;
    localparam int WINDOW_DEPTH   = 5;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int poses_in;
    int means_out;
    int gated;
    int idle_cycles = 0;
    int reg_writes = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    pose_slew_limit_moving_average #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    pose_mean_monitor #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_poses_in   (poses_in),
        .o_means_out  (means_out),
        .o_gated      (gated)
    );

    // Pack pos x,y,z and quat w,x,y,z from the lowest bit up
    function automatic logic [TDATA_W-1:0] pack_pose(
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] y,
        input logic signed [DATA_W-1:0] z,
        input logic [QUAT_W-1:0]        qw,
        input logic [QUAT_W-1:0]        qx,
        input logic [QUAT_W-1:0]        qy,
        input logic [QUAT_W-1:0]        qz
    );
        return {qz, qy, qx, qw, z, y, x};
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly near the gate region, some full range, some at the range ends
    function automatic logic signed [DATA_W-1:0] rand_coord();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            v = int'($urandom_range(0, 589824)) - 294912;
            return v;
        end
        if (r < 85) return $urandom;
        if (r < 92) return S32_MIN + DATA_W'($urandom_range(0, 255));
        return S32_MAX - DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [TDATA_W-1:0] rand_pose();
        return pack_pose(rand_coord(), rand_coord(), rand_coord(), QUAT_W'($urandom),
                         QUAT_W'($urandom), QUAT_W'($urandom), QUAT_W'($urandom));
    endfunction

    // Offer one pose after a random gap and hold it until the transaction
    task automatic send_pose(input logic [TDATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pose(rand_pose());
    endtask

    // Stop offering, wait for every expected mean, then let the design settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_writes++;
    endtask

    // Output side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int gap;
        gap = 0;
        forever begin
            @(posedge clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                gap = HOLD_CYCLES - 1;
            end else begin
                m_tready <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    // End the run when no transaction happens for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: gate edge, range extremes, window fill
        send_pose(pack_pose(32'sd0, 32'sd0, 32'sd0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
        send_pose(pack_pose(32'sd262144, 32'sd0, 32'sd0, 16'h4000, 16'h0001, 16'hC000, 16'h1234));
        send_pose(pack_pose(32'sd262145, 32'sd0, 32'sd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
        send_pose(pack_pose(32'sd0, 32'sd262145, 32'sd0, 16'h5555, 16'h6666, 16'h7777, 16'h8888));
        send_pose(pack_pose(S32_MIN, S32_MIN, S32_MIN, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
        send_pose(pack_pose(-32'sd65536, 32'sd262144, S32_MAX, 16'hAAAA, 16'h5555, 16'h0F0F,
                            16'hF0F0));
        for (int i = 1; i <= 6; i++) begin
            send_pose(pack_pose(DATA_W'(i * 20000), DATA_W'(-i * 15000), DATA_W'(i * 3000),
                                QUAT_W'($urandom), QUAT_W'($urandom), QUAT_W'($urandom),
                                QUAT_W'($urandom)));
        end
        wait_idle();

        // Widest steps, open gate: clamp bounds saturate at both range ends
        write_reg(CFG_STEP_XY, 32'h7FFF_FFFF);
        write_reg(CFG_STEP_Z, 32'h7FFF_FFFF);
        write_reg(CFG_GATE, 32'h7FFF_FFFF);
        hold_req = 1'b1;
        send_pose(pack_pose(S32_MIN, S32_MAX, S32_MIN, 16'h0001, 16'h0002, 16'h0003, 16'h0004));
        send_pose(pack_pose(S32_MAX, S32_MIN, S32_MAX, 16'hFFFE, 16'hFFFD, 16'hFFFC, 16'hFFFB));
        send_pose(pack_pose(S32_MIN, S32_MIN, S32_MIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pose(pack_pose(S32_MAX, S32_MAX, S32_MAX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_random(130);
        wait_idle();

        // Zero z step, wide write to the xy step, gate at the bottom of the range
        write_reg(CFG_STEP_XY, 32'h8000_0100);
        write_reg(CFG_STEP_Z, 32'h0000_0000);
        write_reg(CFG_GATE, 32'h8000_0000);
        send_pose(pack_pose(S32_MIN, S32_MIN, S32_MAX, 16'h1357, 16'h2468, 16'h9ABC, 16'hDEF0));
        send_pose(pack_pose(S32_MIN + 32'sd1, S32_MIN, 32'sd0, 16'h0, 16'h0, 16'h0, 16'h0));
        send_pose(pack_pose(S32_MIN, 32'sd0, 32'sd0, 16'h0, 16'h0, 16'h0, 16'h0));
        send_pose(pack_pose(S32_MIN, S32_MIN, S32_MIN, 16'hCAFE, 16'hBEEF, 16'h0BAD, 16'hF00D));
        send_random(25);
        wait_idle();

        // Random register settings, spare index included
        write_reg(CFG_SPARE, $urandom);
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_STEP_XY, $urandom);
            write_reg(CFG_STEP_Z, {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 131072))});
            write_reg(CFG_GATE, 32'(int'($urandom_range(0, 589824)) - 294912));
            send_random(80);
            wait_idle();
        end

        // Back to reset values, no gaps on either side
        write_reg(CFG_STEP_XY, 32'(STEP_XY_RST));
        write_reg(CFG_STEP_Z, 32'(STEP_Z_RST));
        write_reg(CFG_GATE, GATE_RST);
        no_idle = 1'b1;
        send_random(60);
        no_idle = 1'b0;
        wait_idle();

        $display("Run covered %0d poses in, %0d dropped by the gate, %0d means checked,",
                 poses_in, gated, means_out);
        $display("over %0d register writes and one %0d-cycle output hold-off.",
                 reg_writes, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== pose_slew_limit_moving_average.f =====
rtl/core/psma_pkg.sv
rtl/core/psma_cell.sv
rtl/core/psma_clamp.sv
rtl/core/psma_mean.sv
rtl/core/pose_slew_limit_moving_average.sv
rtl/core/psma_checker.sv
tb/sv/pose_mean_monitor.sv
tb/sv/tb_top.sv
